// File: rtl/button_click_qualifier_defines.svh
// Assertion macros used by the checker file of the click qualifier.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef BUTTON_CLICK_QUALIFIER_DEFINES_SVH
`define BUTTON_CLICK_QUALIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcq_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int SERIES_W = 8;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CLICK = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_AUTO  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_GAP     = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] BOUNCE_RST      = 16'd50;
    localparam logic [CFG_W-1:0] LONG_CLICK_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] AUTO_START_RST  = 16'd0;
    localparam logic [CFG_W-1:0] AUTO_PERIOD_RST = 16'd500;
    localparam logic [CFG_W-1:0] SEQ_GAP_RST     = 16'd0;

    // Hold time is refreshed only while below this limit
    localparam logic [TIME_W-1:0] HOLD_REFRESH_LIMIT = 32'd20000;

    typedef struct packed {
        logic [CFG_W-1:0] bounce_ms;
        logic [CFG_W-1:0] long_click_ms;
        logic [CFG_W-1:0] auto_start_ms;
        logic [CFG_W-1:0] auto_period_ms;
        logic [CFG_W-1:0] sequence_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [SERIES_W-1:0] series_count;
        logic [TIME_W-1:0]   hold_time_ms;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/bcq_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bcq_cfg
    import bcq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register; drop unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BOUNCE:      cfg_next.bounce_ms       = cfg_data;
                REG_LONG_CLICK:  cfg_next.long_click_ms   = cfg_data;
                REG_AUTO_START:  cfg_next.auto_start_ms   = cfg_data;
                REG_AUTO_PERIOD: cfg_next.auto_period_ms  = cfg_data;
                REG_SEQ_GAP:     cfg_next.sequence_gap_ms = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bounce_ms       <= BOUNCE_RST;
            cfg_reg.long_click_ms   <= LONG_CLICK_RST;
            cfg_reg.auto_start_ms   <= AUTO_START_RST;
            cfg_reg.auto_period_ms  <= AUTO_PERIOD_RST;
            cfg_reg.sequence_gap_ms <= SEQ_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/bcq_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bcq_core
    import bcq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic              pin_level,
    input  wire cfg_t              cfg,
    output res_t                   res
);

    logic                pressed_reg, pressed_next;
    logic                long_flag_reg, long_flag_next;
    logic                auto_flag_reg, auto_flag_next;
    logic [TIME_W-1:0]   release_time_reg, release_time_next;
    logic [TIME_W-1:0]   press_time_reg, press_time_next;
    logic [TIME_W-1:0]   last_auto_reg, last_auto_next;
    logic [SERIES_W-1:0] series_reg, series_next;
    logic [TIME_W-1:0]   hold_reg, hold_next;

    logic                low;
    logic [TIME_W-1:0]   d_release;
    logic [TIME_W-1:0]   d_press_old;
    logic [TIME_W-1:0]   d_press;
    logic [TIME_W-1:0]   d_auto;
    logic                long_en;
    logic                auto_en;
    logic                press_hit;
    logic                in_series;
    logic [SERIES_W-1:0] series_new;
    logic                press_click;
    logic                long_f;
    logic                long_hit;
    logic                auto_hit;
    logic                release_hit;
    logic                release_click;
    logic [TIME_W-1:0]   hold_after;
    logic [EVENT_W-1:0]  ev;

    // Elapsed times, all modulo 2^32
    assign low         = !pin_level;
    assign d_release   = now_ms - release_time_reg;
    assign d_press_old = now_ms - press_time_reg;
    assign d_auto      = now_ms - last_auto_reg;
    assign long_en     = (cfg.long_click_ms != '0);
    assign auto_en     = (cfg.auto_start_ms != '0);

    // Press check; a new press restarts the press time, so elapsed is zero
    assign press_hit  = low && !pressed_reg && (d_release > {16'd0, cfg.bounce_ms});
    assign in_series  = (cfg.sequence_gap_ms != '0) && (d_release[15:0] < cfg.sequence_gap_ms);
    assign series_new = in_series ? series_reg + 8'd1 : '0;
    assign press_click = press_hit && !long_en && !auto_en && (series_new == '0);
    assign d_press    = press_hit ? '0 : d_press_old;
    assign long_f     = press_hit ? 1'b0 : long_flag_reg;

    // Long click, then auto-repeat
    assign long_hit = !press_click && low && !long_f && long_en
                      && (d_press > {16'd0, cfg.long_click_ms});
    assign auto_hit = !press_click && !long_hit && low && auto_en
                      && (d_press > {16'd0, cfg.auto_start_ms})
                      && (d_auto > {16'd0, cfg.auto_period_ms});

    // Release check; exclusive with the pressed-level checks above
    assign release_hit   = !low && pressed_reg && (d_press_old > {16'd0, cfg.bounce_ms});
    assign release_click = release_hit && (long_en || auto_en)
                           && !long_flag_reg && !auto_flag_reg;

    assign hold_after = release_hit ? d_press_old : hold_reg;

    // Select the event and the state updates
    always_comb
    begin
        pressed_next      = pressed_reg;
        long_flag_next    = long_flag_reg;
        auto_flag_next    = auto_flag_reg;
        release_time_next = release_time_reg;
        press_time_next   = press_time_reg;
        last_auto_next    = last_auto_reg;
        series_next       = series_reg;
        hold_next         = hold_reg;
        ev                = EV_NONE;

        if (press_hit)
        begin
            pressed_next    = 1'b1;
            long_flag_next  = 1'b0;
            auto_flag_next  = 1'b0;
            series_next     = series_new;
            press_time_next = now_ms;
        end

        if (press_click)
        begin
            ev = EV_CLICK;
        end
        else if (long_hit)
        begin
            long_flag_next = 1'b1;
            ev             = EV_LONG;
        end
        else if (auto_hit)
        begin
            auto_flag_next = 1'b1;
            last_auto_next = now_ms;
            ev             = EV_AUTO;
        end
        else
        begin
            if (release_hit)
            begin
                pressed_next      = 1'b0;
                release_time_next = now_ms;
                hold_next         = d_press_old;
            end
            if (release_click)
            begin
                ev = EV_CLICK;
            end
            else if (hold_after < HOLD_REFRESH_LIMIT)
            begin
                hold_next = d_press;
            end
        end
    end

    // Advance the state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            long_flag_reg    <= 1'b0;
            auto_flag_reg    <= 1'b0;
            release_time_reg <= '0;
            press_time_reg   <= '0;
            last_auto_reg    <= '0;
            series_reg       <= '0;
            hold_reg         <= '0;
        end
        else if (en)
        begin
            pressed_reg      <= pressed_next;
            long_flag_reg    <= long_flag_next;
            auto_flag_reg    <= auto_flag_next;
            release_time_reg <= release_time_next;
            press_time_reg   <= press_time_next;
            last_auto_reg    <= last_auto_next;
            series_reg       <= series_next;
            hold_reg         <= hold_next;
        end
    end

    assign res.event_res    = ev;
    assign res.series_count = series_next;
    assign res.hold_time_ms = hold_next;

endmodule

`default_nettype wire

// File: rtl/button_click_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Push-button click qualifier. Each item carries one sample of an active-low
// button pin and a free-running millisecond time; each item yields exactly one
// result: an event (none, click, long click, auto-repeat click), the current
// count of quick successive presses and the hold time. The block takes one
// item per clock cycle while the output is not stalled. An accepted item
// waits in the input register; the qualifier logic then updates the button
// state and loads the result register. The result register lets the next
// item enter while a finished result still waits. Write the five timing
// registers over the cfg port only while no item is in flight.
module button_click_qualifier
    import bcq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input items
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire logic [TIME_W-1:0]    now_ms,
    input  wire logic                 pin_level,
    // result items
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      logic [EVENT_W-1:0]   event_res,
    output      logic [SERIES_W-1:0]  series_count,
    output      logic [TIME_W-1:0]    hold_time_ms,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg;
    res_t              res;
    res_t              res_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_pin_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_ready;
    logic              advance;
    logic              in_take;

    bcq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .now_ms    (s1_now_reg),
        .pin_level (s1_pin_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Handshake: the result register frees when empty or taken this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_now_reg <= now_ms;
            s1_pin_reg <= pin_level;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg.event_res;
    assign series_count = res_reg.series_count;
    assign hold_time_ms = res_reg.hold_time_ms;

endmodule

`default_nettype wire

// File: rtl/bcq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "button_click_qualifier_defines.svh"

module bcq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  event_res,
    input wire logic [7:0]  series_count,
    input wire logic [31:0] hold_time_ms
);

    // A free output side never holds back the input side
    `BCQ_ASSERT_SAME(a_no_stall_through, !out_stall, !in_stall, "input stalled while output free")

    // An accepted item passes the input register and reaches the output when not stalled
    `BCQ_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid, "item lost in pipeline")

    // Input stalls only while a result is waiting at the output
    `BCQ_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without backpressure")

    // A stalled result holds
    `BCQ_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(event_res) && $stable(series_count) && $stable(hold_time_ms), "stalled item changed")

endmodule

bind button_click_qualifier bcq_checker u_bcq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .series_count (series_count),
    .hold_time_ms (hold_time_ms)
);

`default_nettype wire

// File: tb/button_click_qualifier_tb.sv
`timescale 1ns / 1ps

module button_click_qualifier_tb;
    import bcq_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 48;

    typedef struct {
        logic [TIME_W-1:0] now;
        logic              pin;
    } pin_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [TIME_W-1:0]    now_ms = '0;
    logic                 pin_level = 1'b1;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [EVENT_W-1:0]   event_res;
    logic [SERIES_W-1:0]  series_count;
    logic [TIME_W-1:0]    hold_time_ms;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Samples waiting to be sent and qualified events waiting to come back
    pin_sample_t pin_samples[$];
    res_t        due_events[$];

    // Shadow of the timing registers
    cfg_t timing = '{bounce_ms: BOUNCE_RST, long_click_ms: LONG_CLICK_RST,
                     auto_start_ms: AUTO_START_RST, auto_period_ms: AUTO_PERIOD_RST,
                     sequence_gap_ms: SEQ_GAP_RST};

    // Button state as the qualifier should see it
    logic                btn_down     = 1'b0;
    logic                long_seen    = 1'b0;
    logic                auto_seen    = 1'b0;
    logic [TIME_W-1:0]   release_at   = '0;
    logic [TIME_W-1:0]   press_at     = '0;
    logic [TIME_W-1:0]   last_auto_at = '0;
    logic [SERIES_W-1:0] series_cnt   = '0;
    logic [TIME_W-1:0]   hold_ms      = '0;

    int err_cnt     = 0;
    int queued_cnt  = 0;
    int send_wait   = 0;
    int send_calm   = 0;
    int stall_left  = 0;
    int stall_calm  = 0;
    int idle_cycles = 0;
    logic [TIME_W-1:0] stim_now = '0;

    button_click_qualifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .pin_level    (pin_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .series_count (series_count),
        .hold_time_ms (hold_time_ms),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Qualify one pin sample: press, long click, auto-repeat, release, then hold refresh
    function automatic res_t qualify_sample(logic [TIME_W-1:0] now, logic pin);
        logic              low;
        logic              done;
        logic [EVENT_W-1:0] ev;
        logic [TIME_W-1:0] since_release;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_auto;
        logic [15:0]       gap;
        res_t              r;
        low = ~pin;
        done = 1'b0;
        ev = EV_NONE;
        since_release = now - release_at;
        if (low && !btn_down && since_release > TIME_W'(timing.bounce_ms)) begin
            gap = since_release[15:0];
            long_seen = 1'b0;
            auto_seen = 1'b0;
            btn_down = 1'b1;
            if (timing.sequence_gap_ms != 0 && gap < timing.sequence_gap_ms)
                series_cnt = series_cnt + 1'b1;
            else
                series_cnt = '0;
            press_at = now;
            if (timing.long_click_ms == 0 && timing.auto_start_ms == 0 && series_cnt == 0)
            begin
                ev = EV_CLICK;
                done = 1'b1;
            end
        end
        since_press = now - press_at;
        since_auto = now - last_auto_at;
        // long click ignores whether the press was qualified
        if (!done && low && !long_seen && timing.long_click_ms != 0 &&
            since_press > TIME_W'(timing.long_click_ms)) begin
            long_seen = 1'b1;
            ev = EV_LONG;
            done = 1'b1;
        end
        if (!done && low && timing.auto_start_ms != 0 &&
            since_press > TIME_W'(timing.auto_start_ms) &&
            since_auto > TIME_W'(timing.auto_period_ms)) begin
            auto_seen = 1'b1;
            last_auto_at = now;
            ev = EV_AUTO;
            done = 1'b1;
        end
        if (!done && !low && btn_down && since_press > TIME_W'(timing.bounce_ms)) begin
            btn_down = 1'b0;
            release_at = now;
            hold_ms = since_press;
            if ((timing.long_click_ms != 0 || timing.auto_start_ms != 0) &&
                !long_seen && !auto_seen) begin
                ev = EV_CLICK;
                done = 1'b1;
            end
        end
        // refresh hold time only below the limit
        if (!done && hold_ms < HOLD_REFRESH_LIMIT)
            hold_ms = since_press;
        r.event_res = ev;
        r.series_count = series_cnt;
        r.hold_time_ms = hold_ms;
        return r;
    endfunction

    // Draw the wait before the next item, with occasional stretches of none
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Send pin samples and predict each one as it is accepted
    always @(posedge clk or negedge rst_n) begin : sample_driver
        pin_sample_t nxt;
        logic        keep;
        if (!rst_n) begin
            in_valid <= 1'b0;
            now_ms <= '0;
            pin_level <= 1'b1;
        end else begin
            keep = in_valid;
            if (in_valid && !in_stall) begin
                due_events.push_back(qualify_sample(now_ms, pin_level));
                keep = 1'b0;
                send_wait = draw_wait(send_calm);
            end
            if (!keep) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pin_samples.size() != 0) begin
                    nxt = pin_samples.pop_front();
                    in_valid <= 1'b1;
                    now_ms <= nxt.now;
                    pin_level <= nxt.pin;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Take qualified events and compare them with the oldest prediction
    always @(posedge clk or negedge rst_n) begin : event_monitor
        res_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_events.size() == 0) begin
                    $error("unexpected event item: event_res=%0d series_count=%0d hold_time_ms=%0d",
                           event_res, series_count, hold_time_ms);
                    err_cnt++;
                end else begin
                    want = due_events.pop_front();
                    if (event_res !== want.event_res) begin
                        $error("event_res: expected %0d, actual %0d", want.event_res, event_res);
                        err_cnt++;
                    end
                    if (series_count !== want.series_count) begin
                        $error("series_count: expected %0d, actual %0d",
                               want.series_count, series_count);
                        err_cnt++;
                    end
                    if (hold_time_ms !== want.hold_time_ms) begin
                        $error("hold_time_ms: expected %0d, actual %0d",
                               want.hold_time_ms, hold_time_ms);
                        err_cnt++;
                    end
                end
                stall_left = draw_wait(stall_calm);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Stop a run in which nothing moves
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_sample(logic [TIME_W-1:0] t, logic pin);
        pin_sample_t s;
        s.now = t;
        s.pin = pin;
        pin_samples.push_back(s);
        queued_cnt++;
    endtask

    task automatic step_clock(int max_ms);
        stim_now = stim_now + TIME_W'($urandom_range(0, max_ms));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_BOUNCE:      timing.bounce_ms = val;
            REG_LONG_CLICK:  timing.long_click_ms = val;
            REG_AUTO_START:  timing.auto_start_ms = val;
            REG_AUTO_PERIOD: timing.auto_period_ms = val;
            REG_SEQ_GAP:     timing.sequence_gap_ms = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(cfg_t c);
        write_reg(REG_BOUNCE, c.bounce_ms);
        write_reg(REG_LONG_CLICK, c.long_click_ms);
        write_reg(REG_AUTO_START, c.auto_start_ms);
        write_reg(REG_AUTO_PERIOD, c.auto_period_ms);
        write_reg(REG_SEQ_GAP, c.sequence_gap_ms);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic cfg_t timing_of(int b, int l, int a, int p, int g);
        cfg_t c;
        c.bounce_ms = CFG_W'(b);
        c.long_click_ms = CFG_W'(l);
        c.auto_start_ms = CFG_W'(a);
        c.auto_period_ms = CFG_W'(p);
        c.sequence_gap_ms = CFG_W'(g);
        return c;
    endfunction

    task automatic wait_until_drained();
        while (pin_samples.size() != 0 || in_valid || due_events.size() != 0)
            @(posedge clk);
    endtask

    // One press: released lead-in, optional chatter, hold, optional release chatter; or one to three stray samples
    task automatic queue_press(int tick_max);
        int chatter_max;
        chatter_max = tick_max / 8 + 1;
        if ($urandom_range(0, 9) == 0) begin
            // stray samples at arbitrary times
            repeat ($urandom_range(1, 3)) add_sample($urandom, 1'($urandom_range(0, 1)));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            step_clock(tick_max);
            add_sample(stim_now, 1'b1);
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
                step_clock(chatter_max);
                add_sample(stim_now, 1'b0);
                step_clock(chatter_max);
                add_sample(stim_now, 1'b1);
            end
        end
        repeat ($urandom_range(1, 12)) begin
            step_clock(tick_max);
            add_sample(stim_now, 1'b0);
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
                step_clock(chatter_max);
                add_sample(stim_now, 1'b1);
                step_clock(chatter_max);
                add_sample(stim_now, 1'b0);
            end
        end
    endtask

    task automatic run_phase(cfg_t c, logic [TIME_W-1:0] start_ms, int tick_max);
        int first;
        set_timing(c);
        stim_now = start_ms;
        first = queued_cnt;
        while (queued_cnt - first < PHASE_ITEMS)
            queue_press(tick_max);
        wait_until_drained();
    endtask

    initial begin
        cfg_t c;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing: time extremes, long click, bounce reject, plain click,
        // hold beyond the refresh limit
        add_sample(32'd0, 1'b1);
        add_sample(32'hFFFF_FFFF, 1'b0);
        add_sample(32'd30, 1'b0);
        add_sample(32'd3000, 1'b0);
        add_sample(32'd3100, 1'b1);
        add_sample(32'd3120, 1'b0);
        add_sample(32'd3200, 1'b0);
        add_sample(32'd3300, 1'b1);
        add_sample(32'd3400, 1'b0);
        add_sample(32'd30000, 1'b0);
        add_sample(32'd30010, 1'b1);
        add_sample(32'd30100, 1'b1);
        add_sample(32'd31000, 1'b0);
        add_sample(32'd31100, 1'b1);
        wait_until_drained();

        // Press series with a truncated gap, then click on press
        set_timing(timing_of(0, 0, 0, 0, 65535));
        add_sample(32'd40000, 1'b0);
        add_sample(32'd40001, 1'b1);
        add_sample(32'd105540, 1'b0);
        add_sample(32'd105541, 1'b1);
        add_sample(32'd171076, 1'b0);
        add_sample(32'd171077, 1'b1);
        wait_until_drained();

        // Auto-repeat with zero period, release after auto gives no click
        set_timing(timing_of(5, 65535, 10, 0, 0));
        add_sample(32'd200000, 1'b0);
        add_sample(32'd200011, 1'b0);
        add_sample(32'd200012, 1'b0);
        add_sample(32'd200020, 1'b1);
        wait_until_drained();

        // Random press sequences over several timing settings
        run_phase(timing_of(50, 2000, 0, 500, 0), 32'd1000000, 300);
        run_phase(timing_of(5, 60, 40, 10, 300), 32'hFFFF_F000, 15);
        run_phase(timing_of(0, 0, 0, 0, 65535), $urandom, 8);
        run_phase(timing_of(65535, 65535, 65535, 65535, 65535), $urandom, 20000);
        repeat (4) begin
            c.bounce_ms = CFG_W'($urandom_range(0, 20));
            c.long_click_ms = ($urandom_range(0, 2) == 0) ? '0 : CFG_W'($urandom_range(20, 200));
            c.auto_start_ms = ($urandom_range(0, 2) == 0) ? '0 : CFG_W'($urandom_range(20, 150));
            c.auto_period_ms = CFG_W'($urandom_range(0, 60));
            c.sequence_gap_ms = ($urandom_range(0, 2) == 0) ? '0 : CFG_W'($urandom_range(30, 400));
            run_phase(c, $urandom, 20);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
